### src/dbas_pkg.sv
`timescale 1ns / 1ps
// Package for the decimal add/sub/multiply block: sizes, operation codes,
// payload structs, cell control struct and small digit helpers. No dependencies.
package dbas_pkg;

	localparam int DIGITS = 32;
	localparam int CNT_W  = $clog2(2 * DIGITS);
	localparam int LCNT_W = $clog2(DIGITS + 1);

	// operation codes carried in the mode field of the final pair
	typedef enum logic [1:0] {
		MODE_ADD  = 2'd0,
		MODE_SUB  = 2'd1,
		MODE_MUL  = 2'd2,
		MODE_RSVD = 2'd3
	} dbas_mode_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] digit_a;
		logic [3:0] digit_b;
		logic       last_digit;
	} dbas_in_t;

	typedef struct packed {
		logic [3:0] result_digit;
		logic       negative;
		logic       last_result;
	} dbas_out_t;

	// one command word broadcast to every cell of the chain
	typedef struct packed {
		logic shift_a;
		logic shift_b;
		logic rotate;
		logic mac;
		logic clr;
	} dbas_cell_ctrl_t;

	// digits above nine count as nine
	function automatic logic [3:0] clamp_digit(input logic [3:0] d);
		logic [3:0] r;
		r = (d > 4'd9) ? 4'd9 : d;
		return r;
	endfunction

	// quotient by ten, exact for every 7-bit value (0 to 127)
	function automatic logic [3:0] div10(input logic [6:0] v);
		logic [13:0] p;
		p = 14'(v) * 14'd103;
		return p[13:10];
	endfunction

endpackage

### src/dbas_cell.sv
`timescale 1ns / 1ps
// One digit cell: holds a digit of each operand plus a multiply partial sum
// and carry. Depends on dbas_pkg.
module dbas_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dbas_pkg::dbas_cell_ctrl_t ctrl,
	input  logic                     ld_en,
	input  logic [3:0]               din_a,
	input  logic [3:0]               din_b,
	input  logic [3:0]               nxt_a,
	input  logic [3:0]               nxt_b,
	input  logic [3:0]               s_up,
	input  logic [3:0]               x,
	output logic [3:0]               a_q,
	output logic [3:0]               b_q,
	output logic [3:0]               s_q,
	output logic [3:0]               r
);

	logic [3:0] c_q;
	logic [7:0] prod;
	logic [6:0] v;
	logic [3:0] q;

	// v = x*b + partial sum from above + own carry, at most 99
	assign prod = x * b_q;
	assign v    = prod[6:0] + 7'(s_up) + 7'(c_q);
	assign q    = dbas_pkg::div10(v);
	assign r    = 4'(v - 7'(q) * 7'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			s_q <= '0;
			c_q <= '0;
		end else if (ctrl.clr) begin
			a_q <= '0;
			b_q <= '0;
			s_q <= '0;
			c_q <= '0;
		end else begin
			if (ld_en) begin
				a_q <= din_a;
				b_q <= din_b;
			end
			if (ctrl.shift_a) a_q <= nxt_a;
			if (ctrl.shift_b) b_q <= nxt_b;
			if (ctrl.mac) begin
				s_q <= r;
				c_q <= q;
			end
		end
	end

endmodule

### src/dbas_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the digit chain, serial add/subtract unit at the chain's
// low end, and the result register. Depends on dbas_pkg.
module dbas_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         last_digit,
	input  logic [1:0]                   mode,
	input  logic [3:0]                   a0,
	input  logic [3:0]                   b0,
	input  logic [3:0]                   r0,
	output logic                         busy,
	output logic                         load,
	output logic [dbas_pkg::LCNT_W-1:0]  loaded,
	output dbas_pkg::dbas_cell_ctrl_t    cell_ctrl,
	output logic                         strobe,
	output dbas_pkg::dbas_out_t          result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	localparam int CW = dbas_pkg::CNT_W;
	localparam logic [CW-1:0] CNT_ADD_END = CW'(dbas_pkg::DIGITS);
	localparam logic [CW-1:0] CNT_SUB_END = CW'(dbas_pkg::DIGITS - 1);
	localparam logic [CW-1:0] CNT_MUL_END = CW'(2 * dbas_pkg::DIGITS - 1);

	logic [1:0]    state_q;
	logic [1:0]    op_q;
	logic [CW-1:0] cnt_q;
	logic          carry_q;
	logic          neg_q;
	logic [dbas_pkg::LCNT_W-1:0] loaded_q;

	logic [1:0]    op_in;
	logic          accept;
	logic [4:0]    add_sum;
	logic          add_c;
	logic [3:0]    add_d;
	logic [3:0]    sx, sy;
	logic [4:0]    sub_y;
	logic          sub_bw;
	logic [3:0]    sub_d;
	logic          cmp_bw;
	logic          run_last;
	logic [3:0]    run_digit;
	logic          run_carry;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign load   = accept;
	assign loaded = loaded_q;

	always_comb begin
		case (mode)
			dbas_pkg::MODE_SUB: op_in = dbas_pkg::MODE_SUB;
			dbas_pkg::MODE_MUL: op_in = dbas_pkg::MODE_MUL;
			default:            op_in = dbas_pkg::MODE_ADD;
		endcase
	end

	// add digit
	assign add_sum = 5'(a0) + 5'(b0) + 5'(carry_q);
	assign add_c   = (add_sum >= 5'd10);
	assign add_d   = add_c ? 4'(add_sum - 5'd10) : add_sum[3:0];

	// magnitude subtract digit, larger operand on the left
	assign sx     = neg_q ? b0 : a0;
	assign sy     = neg_q ? a0 : b0;
	assign sub_y  = 5'(sy) + 5'(carry_q);
	assign sub_bw = (5'(sx) < sub_y);
	assign sub_d  = 4'(5'(sx) + (sub_bw ? 5'd10 : 5'd0) - sub_y);

	// compare pass: borrow of a - b only
	assign cmp_bw = ({1'b0, a0} < ({1'b0, b0} + 5'(carry_q)));

	always_comb begin
		case (op_q)
			dbas_pkg::MODE_SUB: begin
				run_last  = (cnt_q == CNT_SUB_END);
				run_digit = sub_d;
				run_carry = sub_bw;
			end
			dbas_pkg::MODE_MUL: begin
				run_last  = (cnt_q == CNT_MUL_END);
				run_digit = r0;
				run_carry = 1'b0;
			end
			default: begin
				run_last  = (cnt_q == CNT_ADD_END);
				run_digit = (cnt_q == CNT_ADD_END) ? 4'(carry_q) : add_d;
				run_carry = add_c;
			end
		endcase
	end

	always_comb begin
		cell_ctrl = '0;
		case (state_q)
			ST_CMP: begin
				cell_ctrl.shift_a = 1'b1;
				cell_ctrl.shift_b = 1'b1;
				cell_ctrl.rotate  = 1'b1;
			end
			ST_RUN: begin
				cell_ctrl.shift_a = 1'b1;
				cell_ctrl.shift_b = (op_q != dbas_pkg::MODE_MUL);
				cell_ctrl.mac     = (op_q == dbas_pkg::MODE_MUL);
				cell_ctrl.clr     = run_last;
			end
			default: cell_ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= dbas_pkg::MODE_ADD;
			cnt_q    <= '0;
			carry_q  <= 1'b0;
			neg_q    <= 1'b0;
			loaded_q <= '0;
			strobe   <= 1'b0;
		end else begin
			strobe <= (state_q == ST_RUN);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (loaded_q < dbas_pkg::LCNT_W'(dbas_pkg::DIGITS))
							loaded_q <= loaded_q + 1'b1;
						if (last_digit) begin
							loaded_q <= '0;
							op_q     <= op_in;
							cnt_q    <= '0;
							carry_q  <= 1'b0;
							neg_q    <= 1'b0;
							state_q  <= (op_in == dbas_pkg::MODE_SUB) ? ST_CMP : ST_RUN;
						end
					end
				end
				ST_CMP: begin
					carry_q <= cmp_bw;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == CNT_SUB_END) begin
						neg_q   <= cmp_bw;
						carry_q <= 1'b0;
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					carry_q <= run_carry;
					cnt_q   <= cnt_q + 1'b1;
					if (run_last)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			result.result_digit <= run_digit;
			result.negative     <= neg_q && (op_q == dbas_pkg::MODE_SUB);
			result.last_result  <= run_last;
		end
	end

	// run ends with its final digit in the output register
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && result.last_result)
		else $error("busy dropped without a final result");

	// only the final digit shows while idle
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_result |-> busy)
		else $error("non-final result outside a run");

	// sign only in subtract runs
	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.negative |-> op_q == dbas_pkg::MODE_SUB)
		else $error("negative flag outside subtract");

	// final add digit is the carry
	a_carry: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_result && op_q == dbas_pkg::MODE_ADD
		|-> result.result_digit <= 4'd1)
		else $error("add carry digit above one");

endmodule

### src/decimal_bigint_add_sub_mul_top.sv
`timescale 1ns / 1ps
// Top level of the decimal add/subtract/multiply block: a row of digit
// cells and the sequencer. Depends on dbas_pkg, dbas_cell, dbas_ctrl.
//
// Usage:
//   Operand digit pairs come in on operands, least significant first, one
//   transfer per cycle at each edge with start high and busy low. Pairs beyond
//   DIGITS are dropped; missing digits read as zero. The pair marked
//   last_digit starts a run in the mode it carries (mode 3 runs as add).
//   Results leave on result, one digit per cycle, each shown for one cycle
//   with strobe high, least significant first, the final one flagged with
//   last_result. The receiver has no way to stall: it must take every digit.
//   After the final transfer: add gives DIGITS+1 digits, one per cycle,
//   the first after the sequencer has entered its run state; subtract first
//   rotates the chain once to find the sign, then gives DIGITS digits;
//   multiply gives 2*DIGITS digits, one per cycle. busy drops in the cycle
//   the final digit shows, so the next operand transfer can overlap it.
//   The run length is set by the digit chain: one digit leaves the low cell
//   per cycle, and multiply runs on past the operand digits to flush the carries.
//   Reset (arst_n low) clears all cell digits and the load count; after each run
//   the operands are cleared again.
module decimal_bigint_add_sub_mul_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  dbas_pkg::dbas_in_t  operands,
	output logic                strobe,
	output dbas_pkg::dbas_out_t result
);

	localparam int N = dbas_pkg::DIGITS;

	dbas_pkg::dbas_cell_ctrl_t cell_ctrl;
	logic                      load;
	logic [dbas_pkg::LCNT_W-1:0] loaded;
	logic [3:0]                din_a, din_b;

	// per-cell digit registers, partial sums and remainders
	logic [3:0] a_q [N];
	logic [3:0] b_q [N];
	logic [3:0] s_q [N];
	logic [3:0] r   [N];
	logic [3:0] top_a, top_b;

	assign din_a = dbas_pkg::clamp_digit(operands.digit_a);
	assign din_b = dbas_pkg::clamp_digit(operands.digit_b);

	// the top cell takes zeros, or the low cell's digits while rotating
	assign top_a = cell_ctrl.rotate ? a_q[0] : 4'd0;
	assign top_b = cell_ctrl.rotate ? b_q[0] : 4'd0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic       ld_en;
		logic [3:0] nxt_a, nxt_b, s_up;

		assign ld_en = load && (loaded == dbas_pkg::LCNT_W'(i));

		if (i == N - 1) begin : g_top
			assign nxt_a = top_a;
			assign nxt_b = top_b;
			assign s_up  = 4'd0;
		end else begin : g_mid
			assign nxt_a = a_q[i+1];
			assign nxt_b = b_q[i+1];
			assign s_up  = s_q[i+1];
		end

		// multiplier digit a is taken from the low cell and broadcast
		dbas_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (cell_ctrl),
			.ld_en  (ld_en),
			.din_a  (din_a),
			.din_b  (din_b),
			.nxt_a  (nxt_a),
			.nxt_b  (nxt_b),
			.s_up   (s_up),
			.x      (a_q[0]),
			.a_q    (a_q[i]),
			.b_q    (b_q[i]),
			.s_q    (s_q[i]),
			.r      (r[i])
		);
	end

	dbas_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.last_digit (operands.last_digit),
		.mode       (operands.mode),
		.a0         (a_q[0]),
		.b0         (b_q[0]),
		.r0         (r[0]),
		.busy       (busy),
		.load       (load),
		.loaded     (loaded),
		.cell_ctrl  (cell_ctrl),
		.strobe     (strobe),
		.result     (result)
	);

endmodule
